[hdl/fragmenting_stop_and_wait_sender_core_assert.svh]
// Assertion macros for the fragment sender core
`ifndef FRAGMENTING_STOP_AND_WAIT_SENDER_CORE_ASSERT_SVH
`define FRAGMENTING_STOP_AND_WAIT_SENDER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define FSW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define FSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hdl/fswsnd_pkg.sv]
// ----------------------------------------------------------------------------
// fswsnd_pkg
// Shared types and constants of the fragment sender core.
// ----------------------------------------------------------------------------
`default_nettype none
package fswsnd_pkg;
   localparam int unsigned HeaderBytes = 24;
   localparam logic [15:0] MaxFragments = 16'hffff;

   localparam logic [1:0] FuncStart = 2'd0;
   localparam logic [1:0] FuncFrame = 2'd1;
   localparam logic [1:0] FuncReadFail = 2'd2;
   localparam logic [1:0] FuncWriteFail = 2'd3;

   localparam logic [3:0] StSend = 4'd0;
   localparam logic [3:0] StDelivered = 4'd1;
   localparam logic [3:0] StNotConnected = 4'd2;
   localparam logic [3:0] StMtuSmall = 4'd3;
   localparam logic [3:0] StTooMany = 4'd4;
   localparam logic [3:0] StNotAcked = 4'd5;
   localparam logic [3:0] StReadFailed = 4'd6;
   localparam logic [3:0] StWriteFailed = 4'd7;
   localparam logic [3:0] StIgnored = 4'd8;

   localparam logic CsrMaxRetries = 1'b0;
   localparam logic CsrLinkMtu = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch input word
      logic div_start;    // begin fragment count division
      logic div_step;     // one quotient bit
      logic start_pkt;    // load packet state
      logic next_frag;    // advance fragment
      logic retry;        // bump attempt count
      logic clear_busy;   // drop busy
      logic load_rsp;     // load result register
      logic [3:0] status; // result status
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
      logic [1:0] func;
      logic connected;
      logic mtu_small;
      logic div_done;
      logic too_many;
      logic ack_match;
      logic last_frag;
      logic retry_out;
   } sts_type;
endpackage
`default_nettype wire

[hdl/fswsnd_ctrl.sv]
// ----------------------------------------------------------------------------
// fswsnd_ctrl
// Event sequencer: decodes the captured word and drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module fswsnd_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_fire,
   input  wire logic rsp_free,
   input  wire fswsnd_pkg::sts_type sts,
   output fswsnd_pkg::ctl_type ctl,
   output logic req_ready
);
   typedef enum logic [1:0] {IDLE, DECODE, DIVIDE, EMIT} state_type;
   state_type state_ff, state_in;
   logic [3:0] status_ff, status_in;

   // next state and commands
   always_comb begin
      ctl = '0;
      state_in = state_ff;
      status_in = status_ff;
      ctl.status = status_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               ctl.capture = 1'b1;
               state_in = DECODE;
            end
         end
         DECODE: begin
            state_in = EMIT;
            if (sts.func == fswsnd_pkg::FuncStart) begin
               if (sts.busy) status_in = fswsnd_pkg::StIgnored;
               else if (!sts.connected) status_in = fswsnd_pkg::StNotConnected;
               else if (sts.mtu_small) status_in = fswsnd_pkg::StMtuSmall;
               else begin
                  ctl.div_start = 1'b1;
                  state_in = DIVIDE;
               end
            end else if (!sts.busy) begin
               status_in = fswsnd_pkg::StIgnored;
            end else if (sts.func == fswsnd_pkg::FuncWriteFail) begin
               ctl.clear_busy = 1'b1;
               status_in = fswsnd_pkg::StWriteFailed;
            end else if (sts.func == fswsnd_pkg::FuncFrame && sts.ack_match) begin
               if (sts.last_frag) begin
                  ctl.clear_busy = 1'b1;
                  status_in = fswsnd_pkg::StDelivered;
               end else begin
                  ctl.next_frag = 1'b1;
                  status_in = fswsnd_pkg::StSend;
               end
            end else if (sts.retry_out) begin
               ctl.clear_busy = 1'b1;
               status_in = (sts.func == fswsnd_pkg::FuncFrame) ?
                  fswsnd_pkg::StNotAcked : fswsnd_pkg::StReadFailed;
            end else begin
               ctl.retry = 1'b1;
               status_in = fswsnd_pkg::StSend;
            end
         end
         DIVIDE: begin
            if (sts.div_done) begin
               state_in = EMIT;
               if (sts.too_many) status_in = fswsnd_pkg::StTooMany;
               else begin
                  ctl.start_pkt = 1'b1;
                  status_in = fswsnd_pkg::StSend;
               end
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         EMIT: begin
            if (rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   assign req_ready = (state_ff == IDLE);

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         status_ff <= fswsnd_pkg::StSend;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
      end
   end
endmodule
`default_nettype wire

[hdl/fswsnd_dpath.sv]
// ----------------------------------------------------------------------------
// fswsnd_dpath
// Packet state, restoring divider for the fragment count, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module fswsnd_dpath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [83:0] req_word,
   input  wire logic csr_fire,
   input  wire logic csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire fswsnd_pkg::ctl_type ctl,
   output fswsnd_pkg::sts_type sts,
   input  wire logic rsp_ready,
   output logic rsp_valid,
   output logic rsp_free,
   output logic [148:0] rsp_word
);
   logic [7:0] retry_limit_ff;
   logic [15:0] link_mtu_ff;
   logic [83:0] in_ff;
   logic busy_ff;
   logic [31:0] next_seq_ff, cur_seq_ff, offset_ff, psize_ff;
   logic [15:0] pos_ff, total_ff, cap_ff;
   logic [7:0] attempt_ff;
   logic [32:0] dividend_ff, quot_ff;
   logic [15:0] rem_ff;
   logic [5:0] count_ff;
   logic rsp_valid_ff;
   logic [148:0] rsp_ff;

   logic [1:0] func;
   logic [31:0] size, ack_seq;
   logic [15:0] ack_idx, cap_new, len;
   logic [16:0] rem_sh;
   logic [17:0] rem_try;
   logic [31:0] remaining;

   assign func = in_ff[1:0];
   assign size = in_ff[33:2];
   assign ack_seq = in_ff[66:35];
   assign ack_idx = in_ff[82:67];
   assign cap_new = link_mtu_ff - 16'(fswsnd_pkg::HeaderBytes);
   assign rem_sh = {rem_ff, dividend_ff[32]};
   assign rem_try = {1'b0, rem_sh} - {2'b0, cap_new};
   assign remaining = psize_ff - offset_ff;
   assign len = (remaining < {16'd0, cap_ff}) ? remaining[15:0] : cap_ff;

   always_comb begin
      sts.busy = busy_ff;
      sts.func = func;
      sts.connected = in_ff[34];
      sts.mtu_small = (link_mtu_ff <= 16'(fswsnd_pkg::HeaderBytes));
      sts.div_done = (count_ff == 6'd33);
      sts.too_many = (quot_ff > {17'd0, fswsnd_pkg::MaxFragments});
      sts.ack_match = in_ff[83] && (ack_seq == cur_seq_ff) && (ack_idx == pos_ff);
      sts.last_frag = ({1'b0, pos_ff} + 17'd1 >= {1'b0, total_ff});
      sts.retry_out = (attempt_ff >= retry_limit_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // config, control flags and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= 8'd3;
         link_mtu_ff <= 16'd1024;
         busy_ff <= 1'b0;
         next_seq_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            if (csr_index == fswsnd_pkg::CsrMaxRetries) retry_limit_ff <= csr_wdata[7:0];
            else link_mtu_ff <= csr_wdata;
         end
         if (ctl.start_pkt) begin
            busy_ff <= 1'b1;
            next_seq_ff <= next_seq_ff + 32'd1;
         end
         if (ctl.clear_busy) busy_ff <= 1'b0;
         if (ctl.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // packet state, divider and result payload
   always_ff @(posedge clock) begin
      if (ctl.capture) in_ff <= req_word;
      if (ctl.div_start) begin
         // ceil(size/cap) = floor((size+cap-1)/cap)
         dividend_ff <= {1'b0, size} + {17'd0, cap_new} - 33'd1;
         rem_ff <= '0;
         quot_ff <= '0;
         count_ff <= '0;
      end else if (ctl.div_step) begin
         dividend_ff <= {dividend_ff[31:0], 1'b0};
         count_ff <= count_ff + 6'd1;
         if (!rem_try[17]) begin
            rem_ff <= rem_try[15:0];
            quot_ff <= {quot_ff[31:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[15:0];
            quot_ff <= {quot_ff[31:0], 1'b0};
         end
      end
      if (ctl.start_pkt) begin
         cur_seq_ff <= next_seq_ff;
         pos_ff <= '0;
         total_ff <= (quot_ff == 33'd0) ? 16'd1 : quot_ff[15:0];
         attempt_ff <= '0;
         offset_ff <= '0;
         psize_ff <= size;
         cap_ff <= cap_new;
      end
      if (ctl.next_frag) begin
         pos_ff <= pos_ff + 16'd1;
         offset_ff <= offset_ff + {16'd0, cap_ff};
         attempt_ff <= '0;
      end
      if (ctl.retry) attempt_ff <= attempt_ff + 8'd1;
      if (ctl.load_rsp) begin
         if (ctl.status == fswsnd_pkg::StSend)
            rsp_ff <= {psize_ff,
                       ({1'b0, pos_ff} + 17'd1 == {1'b0, total_ff}),
                       len, offset_ff, total_ff, pos_ff, cur_seq_ff, ctl.status};
         else
            rsp_ff <= {145'd0, ctl.status};
      end
   end
   // keep reset in use for busy-related flops above; payload needs none
endmodule
`default_nettype wire

[hdl/fragmenting_stop_and_wait_sender_core.sv]
// Each accepted word is decoded into a result; a start that passes its checks first
// runs the 33-step divider (accepted start or too many fragments).
// One word at a time: the next is accepted in the cycle after the result register
// loads, and output stalls hold the result and so the input.
// The fragment count comes from a restoring divider, one quotient bit per cycle.
// Reset (synchronous, high) clears busy and sequence; retry limit 3, link MTU 1024.
// ----------------------------------------------------------------------------
// fragmenting_stop_and_wait_sender_core
// Top level: streaming event in, fragment descriptor out.
// ----------------------------------------------------------------------------
`default_nettype none
module fragmenting_stop_and_wait_sender_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // func
   input  wire logic [1:0] req_tuser,
   // payload_size, link_connected, ack_sequence, ack_index, ack_flag, pad
   input  wire logic [87:0] req_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // status
   output logic [3:0] rsp_tuser,
   // frame_sequence, frame_index, frame_count, frame_offset,
   // frame_length, frame_end, total packet size, pad
   output logic [151:0] rsp_tdata,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [0:0] csr_index,
   input  wire logic [15:0] csr_wdata
);
   fswsnd_pkg::ctl_type ctl;
   fswsnd_pkg::sts_type sts;
   logic rsp_free;
   logic [148:0] word;

   assign csr_ready = 1'b1;

   fswsnd_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready), .rsp_free(rsp_free),
      .sts(sts), .ctl(ctl), .req_ready(req_tready)
   );

   fswsnd_dpath u_dpath (
      .clock(clock), .reset(reset),
      .req_word({req_tdata[81:0], req_tuser}),
      .csr_fire(csr_valid), .csr_index(csr_index[0]), .csr_wdata(csr_wdata),
      .ctl(ctl), .sts(sts),
      .rsp_ready(rsp_tready), .rsp_valid(rsp_tvalid), .rsp_free(rsp_free),
      .rsp_word(word)
   );

   // split result: status to tuser, descriptor to tdata
   assign rsp_tuser = word[3:0];
   assign rsp_tdata = {7'd0, word[148:4]};
endmodule
`default_nettype wire

[hdl/fswsnd_checker.sv]
// ----------------------------------------------------------------------------
// fswsnd_checker
// Port-level checks of the fragment sender core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fragmenting_stop_and_wait_sender_core_assert.svh"
module fswsnd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [3:0] rsp_tuser,
   input wire logic [151:0] rsp_tdata
);
   // a stalled result holds
   `FSW_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // an accepted word blocks the input next cycle
   `FSW_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // non-send status carries no descriptor
   `FSW_ASSERT_IMP(a_zero, clock, reset, rsp_tvalid && rsp_tuser != fswsnd_pkg::StSend, rsp_tdata == '0)
   // status stays in range
   `FSW_ASSERT_IMP(a_range, clock, reset, rsp_tvalid, rsp_tuser <= fswsnd_pkg::StIgnored)
endmodule
bind fragmenting_stop_and_wait_sender_core fswsnd_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
   .rsp_tdata(rsp_tdata)
);
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the fragment sender core against a cycle-free model of its packet
// state. Directed checks cover rejects, retries and config changes made while
// a packet is in flight. Random packet sessions with acks, bad acks and
// failures follow. Each response word is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] sequence_no;
      logic [15:0] index;
      logic [15:0] count;
      logic [31:0] offset;
      logic [15:0] length;
      logic        last_frag;
      logic [31:0] total_size;
   } descriptor_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [87:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [3:0] rsp_tuser;
   logic [151:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   fragmenting_stop_and_wait_sender_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the sender state
   logic [7:0]  retry_limit;
   logic [15:0] mtu;
   logic        in_flight;
   logic [31:0] seq_next, seq_cur;
   logic [15:0] frag_pos, frag_total, frag_cap;
   logic [7:0]  attempts;
   logic [31:0] bytes_sent, pkt_size;

   descriptor_type pending_frames[$];
   int error_count = 0;
   bit no_idle = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("testbench: errors");
      $finish;
   end

   function automatic descriptor_type status_only(logic [3:0] st);
      descriptor_type d;
      d = '0;
      d.status = st;
      return d;
   endfunction

   function automatic descriptor_type current_fragment();
      descriptor_type d;
      logic [31:0] remaining;
      remaining = pkt_size - bytes_sent;
      d.status = fswsnd_pkg::StSend;
      d.sequence_no = seq_cur;
      d.index = frag_pos;
      d.count = frag_total;
      d.offset = bytes_sent;
      d.length = (remaining < {16'd0, frag_cap}) ? remaining[15:0] : frag_cap;
      d.last_frag = ({16'd0, frag_pos} + 32'd1 == {16'd0, frag_total});
      d.total_size = pkt_size;
      return d;
   endfunction

   function automatic descriptor_type retransmit_or_fail(logic [3:0] fail_st);
      if (attempts >= retry_limit) begin
         in_flight = 1'b0;
         return status_only(fail_st);
      end
      attempts = attempts + 8'd1;
      return current_fragment();
   endfunction

   // advance the shadow state by one event word and return its response
   function automatic descriptor_type next_descriptor(logic [1:0] func, logic [31:0] size,
         logic connected, logic [31:0] ack_seq, logic [15:0] ack_idx, logic ack_flag);
      logic [31:0] cap;
      logic [63:0] frags;
      if (func == fswsnd_pkg::FuncStart) begin
         if (in_flight) return status_only(fswsnd_pkg::StIgnored);
         if (!connected) return status_only(fswsnd_pkg::StNotConnected);
         if (mtu <= fswsnd_pkg::HeaderBytes) return status_only(fswsnd_pkg::StMtuSmall);
         cap = {16'd0, mtu} - fswsnd_pkg::HeaderBytes;
         frags = ({32'd0, size} + {32'd0, cap} - 64'd1) / {32'd0, cap};
         if (frags < 64'd1) frags = 64'd1;
         if (frags > {48'd0, fswsnd_pkg::MaxFragments})
            return status_only(fswsnd_pkg::StTooMany);
         seq_cur = seq_next;
         seq_next = seq_next + 32'd1;
         in_flight = 1'b1;
         frag_pos = '0;
         frag_total = frags[15:0];
         attempts = '0;
         bytes_sent = '0;
         pkt_size = size;
         frag_cap = cap[15:0];
         return current_fragment();
      end
      if (!in_flight) return status_only(fswsnd_pkg::StIgnored);
      if (func == fswsnd_pkg::FuncFrame) begin
         if (!(ack_flag && ack_seq == seq_cur && ack_idx == frag_pos))
            return retransmit_or_fail(fswsnd_pkg::StNotAcked);
         if ({16'd0, frag_pos} + 32'd1 >= {16'd0, frag_total}) begin
            in_flight = 1'b0;
            return status_only(fswsnd_pkg::StDelivered);
         end
         frag_pos = frag_pos + 16'd1;
         bytes_sent = bytes_sent + {16'd0, frag_cap};
         attempts = '0;
         return current_fragment();
      end
      if (func == fswsnd_pkg::FuncReadFail)
         return retransmit_or_fail(fswsnd_pkg::StReadFailed);
      in_flight = 1'b0;
      return status_only(fswsnd_pkg::StWriteFailed);
   endfunction

   // hand one event word to the core, with an optional gap first
   task automatic send_event(logic [1:0] func, logic [31:0] size = '0, logic connected = 1'b1,
         logic [31:0] ack_seq = '0, logic [15:0] ack_idx = '0, logic ack_flag = 1'b0);
      if (!no_idle && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {6'd0, ack_flag, ack_idx, ack_seq, connected, size};
      do @(posedge clock); while (!req_tready);
      pending_frames.push_back(next_descriptor(func, size, connected, ack_seq, ack_idx,
                                               ack_flag));
   endtask

   task automatic send_ack();
      send_event(fswsnd_pkg::FuncFrame, $urandom, 1'($urandom_range(0, 1)), seq_cur,
                 frag_pos, 1'b1);
   endtask

   // stop sending and let every response come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == fswsnd_pkg::CsrMaxRetries) retry_limit = value[7:0];
      else mtu = value;
   endtask

   // result port: random backpressure
   always @(posedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
   end

   // compare each response word with the oldest expectation
   always @(posedge clock) begin
      descriptor_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32], rsp_tdata[63:48],
                rsp_tdata[95:64], rsp_tdata[111:96], rsp_tdata[112], rsp_tdata[144:113]};
         if (pending_frames.size() == 0) begin
            $error("unexpected response word %h %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_frames.pop_front();
            if (got.status != want.status) begin
               $error("status: expected %0d got %0d", want.status, got.status);
               error_count++;
            end
            if (got.sequence_no != want.sequence_no) begin
               $error("frame_sequence: expected %0d got %0d", want.sequence_no,
                      got.sequence_no);
               error_count++;
            end
            if (got.index != want.index) begin
               $error("frame_index: expected %0d got %0d", want.index, got.index);
               error_count++;
            end
            if (got.count != want.count) begin
               $error("frame_count: expected %0d got %0d", want.count, got.count);
               error_count++;
            end
            if (got.offset != want.offset) begin
               $error("frame_offset: expected %0d got %0d", want.offset, got.offset);
               error_count++;
            end
            if (got.length != want.length) begin
               $error("frame_length: expected %0d got %0d", want.length, got.length);
               error_count++;
            end
            if (got.last_frag != want.last_frag) begin
               $error("frame_end: expected %0d got %0d", want.last_frag, got.last_frag);
               error_count++;
            end
            if (got.total_size != want.total_size) begin
               $error("frame_total: expected %0d got %0d", want.total_size,
                      got.total_size);
               error_count++;
            end
         end
      end
   end

   // rejects, ignored words and the basic packet flow
   task automatic test_rejects_and_flow();
      send_event(fswsnd_pkg::FuncFrame, '1, 1'b1, '1, '1, 1'b1);   // idle: ignored
      send_event(fswsnd_pkg::FuncReadFail);
      send_event(fswsnd_pkg::FuncWriteFail);
      send_event(fswsnd_pkg::FuncStart, 32'd100, 1'b0);            // link down
      send_event(fswsnd_pkg::FuncStart, 32'd0);                    // empty packet
      send_event(fswsnd_pkg::FuncStart, 32'd50);                   // busy: ignored
      send_ack();
      send_event(fswsnd_pkg::FuncStart, 32'd2500);                 // three fragments
      send_event(fswsnd_pkg::FuncFrame, seq_cur, 1'b1, seq_cur, frag_pos, 1'b0);
      send_event(fswsnd_pkg::FuncFrame, 32'd0, 1'b1, seq_cur + 32'd1, frag_pos, 1'b1);
      send_ack();
      send_event(fswsnd_pkg::FuncFrame, 32'd0, 1'b1, seq_cur, frag_pos + 16'd1, 1'b1);
      send_ack();
      send_ack();
      send_event(fswsnd_pkg::FuncStart, '1, 1'b1);                 // too many at 1000 B
      drain();
      write_csr(fswsnd_pkg::CsrLinkMtu, 16'd24);
      send_event(fswsnd_pkg::FuncStart, 32'd1);
      drain();
      write_csr(fswsnd_pkg::CsrLinkMtu, 16'd25);
      send_event(fswsnd_pkg::FuncStart, 32'd65536);
      send_event(fswsnd_pkg::FuncStart, 32'd65535);
      send_event(fswsnd_pkg::FuncWriteFail);
      drain();
      write_csr(fswsnd_pkg::CsrLinkMtu, 16'hffff);
      send_event(fswsnd_pkg::FuncStart, '1);
      send_event(fswsnd_pkg::FuncStart, 32'd65511 * 32'd3 + 32'd7);
      send_ack();
      send_event(fswsnd_pkg::FuncWriteFail);
      drain();
   endtask

   // retry limit changes, including in flight
   task automatic test_retries();
      int i;
      write_csr(fswsnd_pkg::CsrLinkMtu, 16'd1024);
      write_csr(fswsnd_pkg::CsrMaxRetries, 16'd0);
      send_event(fswsnd_pkg::FuncStart, 32'd10);
      send_event(fswsnd_pkg::FuncReadFail);
      drain();
      write_csr(fswsnd_pkg::CsrMaxRetries, 16'd255);
      send_event(fswsnd_pkg::FuncStart, 32'd10);
      for (i = 0; i < 256; i++) begin
         if (i[0]) send_event(fswsnd_pkg::FuncReadFail);
         else send_event(fswsnd_pkg::FuncFrame, $urandom, 1'b1, $urandom,
                         16'($urandom), 1'b0);
      end
      drain();
      write_csr(fswsnd_pkg::CsrMaxRetries, 16'd3);
      send_event(fswsnd_pkg::FuncStart, 32'd10);
      send_event(fswsnd_pkg::FuncReadFail);
      send_event(fswsnd_pkg::FuncReadFail);
      drain();
      write_csr(fswsnd_pkg::CsrMaxRetries, 16'd1);                // lowered in flight
      send_event(fswsnd_pkg::FuncReadFail);
      drain();
   endtask

   // mtu changed in flight keeps the capacity the packet started with
   task automatic test_mtu_in_flight();
      write_csr(fswsnd_pkg::CsrMaxRetries, 16'd3);
      write_csr(fswsnd_pkg::CsrLinkMtu, 16'd1024);
      send_event(fswsnd_pkg::FuncStart, 32'd3000);
      drain();
      write_csr(fswsnd_pkg::CsrLinkMtu, 16'd100);
      send_ack();
      send_ack();
      send_ack();
      drain();
   endtask

   // random packet sessions under one setting
   task automatic test_random_sessions(logic [15:0] mtu_value, logic [7:0] retries,
         int num_words);
      int n, pick;
      logic [31:0] cap, size;
      write_csr(fswsnd_pkg::CsrLinkMtu, mtu_value);
      write_csr(fswsnd_pkg::CsrMaxRetries, {8'd0, retries});
      cap = (mtu > fswsnd_pkg::HeaderBytes) ?
            ({16'd0, mtu} - fswsnd_pkg::HeaderBytes) : 32'd1;
      for (n = 0; n < num_words; n++) begin
         pick = $urandom_range(0, 99);
         if (!in_flight) begin
            if (pick < 8) send_event(2'($urandom_range(1, 3)), $urandom,
                                     1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                                     1'($urandom_range(0, 1)));
            else begin
               if (pick < 70) size = $urandom_range(0, (cap * 4 > 32'd200000) ?
                                                       200000 : cap * 4);
               else if (pick < 80) size = 32'd0;
               else size = $urandom;
               send_event(fswsnd_pkg::FuncStart, size, $urandom_range(0, 99) < 92);
            end
         end else if (pick < 62) send_ack();
         else if (pick < 72) begin
            case ($urandom_range(0, 2))
               0: send_event(fswsnd_pkg::FuncFrame, $urandom, 1'b1,
                             seq_cur ^ (32'd1 << $urandom_range(0, 31)), frag_pos, 1'b1);
               1: send_event(fswsnd_pkg::FuncFrame, $urandom, 1'b1, seq_cur,
                             frag_pos ^ (16'd1 << $urandom_range(0, 15)), 1'b1);
               default: send_event(fswsnd_pkg::FuncFrame, $urandom, 1'b1, seq_cur,
                                   frag_pos, 1'b0);
            endcase
         end
         else if (pick < 85) send_event(fswsnd_pkg::FuncReadFail, $urandom);
         else if (pick < 89) send_event(fswsnd_pkg::FuncWriteFail, $urandom);
         else if (pick < 94) send_event(fswsnd_pkg::FuncStart, $urandom,
                                        1'($urandom_range(0, 1)));
         else send_event(fswsnd_pkg::FuncFrame, $urandom, 1'($urandom_range(0, 1)),
                         $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
      end
      drain();
   endtask

   initial begin
      retry_limit = 8'd3;
      mtu = 16'd1024;
      in_flight = 1'b0;
      seq_next = '0;
      seq_cur = '0;
      frag_pos = '0;
      frag_total = '0;
      frag_cap = '0;
      attempts = '0;
      bytes_sent = '0;
      pkt_size = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_rejects_and_flow();
      test_retries();
      test_mtu_in_flight();
      test_random_sessions(16'd1024, 8'd3, 40);
      test_random_sessions(16'd25, 8'd1, 30);
      no_idle = 1'b1;
      test_random_sessions(16'd100, 8'd2, 50);
      no_idle = 1'b0;
      test_random_sessions(16'hffff, 8'd0, 30);
      test_random_sessions(16'd0, 8'd255, 15);
      test_random_sessions(16'(16'd24 + $urandom_range(1, 2000)),
                           8'($urandom_range(0, 6)), 50);
      drain();
      if (error_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end
endmodule
`default_nettype wire
